// ===== sv/accel_tilt_roll_pitch_unit_assert.svh =====
// assertion macros used by the tilt unit top-level source
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH

// checked only outside reset
`define ATRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define ATRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/atrp_pkg.sv =====
// shared types, constants and elaboration-time arctangent table for the tilt unit
// no dependencies
package atrp_pkg;

  localparam int WORD_BITS    = 64;
  localparam int ROOT_BITS    = 32;
  localparam int REM_BITS     = 34;
  localparam int ANG_FRAC     = 44;
  localparam int ANG_BITS     = 48;
  localparam int CORDIC_STEPS = 48;
  localparam int NORM_STAGES  = 5;
  localparam int CLAMP_BITS   = 46;
  localparam int PROD_BITS    = 61;
  localparam int MAG_BITS     = 14;
  localparam int OUT_BITS     = 15;

  localparam logic signed [OUT_BITS-1:0] RIGHT_ANGLE = 15'sd9000;

  typedef logic [WORD_BITS-1:0]        word_t;
  typedef logic signed [WORD_BITS-1:0] sword_t;
  typedef logic [ROOT_BITS-1:0]        root_t;
  typedef logic [REM_BITS-1:0]         rem_t;
  typedef logic signed [ANG_BITS-1:0]  angle_t;

  // per-item side information that rides alongside the datapath
  typedef struct packed {
    logic neg;
    logic num_zero;
    logic den_zero;
  } tilt_flags_t;

  // bitwise restoring divide, used only when building constants
  function automatic word_t udiv(input word_t num, input word_t den);
    logic [WORD_BITS:0] r;
    word_t q;
    r = '0;
    q = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      r = {r[WORD_BITS-1:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) in Q62 by the alternating series
  function automatic word_t atan_inv_q62(input word_t m);
    word_t p;
    word_t sum;
    word_t t;
    logic done;
    p = udiv(word_t'(1) << 62, m);
    sum = p;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        p = udiv(p, m);
        p = udiv(p, m);
        if (p == '0) begin
          done = 1'b1;
        end else begin
          t = udiv(p, word_t'(2 * k + 1));
          if ((k & 1) != 0) begin
            sum = sum - t;
          end else begin
            sum = sum + t;
          end
        end
      end
    end
    return sum;
  endfunction

  // floor of atan(2^-i) in units where pi/4 is 2^ANG_FRAC
  function automatic word_t atan_entry(input int i);
    word_t qp;
    word_t r;
    word_t q;
    qp = (atan_inv_q62(word_t'(5)) << 2) - atan_inv_q62(word_t'(239));
    q = '0;
    if (i == 0) begin
      q = word_t'(1) << ANG_FRAC;
    end else begin
      r = atan_inv_q62(word_t'(1) << i);
      for (int b = 0; b < ANG_FRAC; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= qp) begin
          r = r - qp;
          q[0] = 1'b1;
        end
      end
    end
    return q;
  endfunction

endpackage

// ===== sv/atrp_norm.sv =====
// front end: magnitudes, squares, sum of squares and block normalisation
// depends on atrp_pkg
module atrp_norm #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS:0]   num,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  output logic                          out_valid,
  output atrp_pkg::word_t               dsq,
  output atrp_pkg::word_t               n,
  output atrp_pkg::tilt_flags_t         flags
);

  localparam int SB = SAMPLE_BITS;
  localparam int SQ_BITS = 2 * SAMPLE_BITS;
  localparam int NS = atrp_pkg::NORM_STAGES;

  logic signed [SB:0] num_abs;
  logic signed [SB:0] a_ext;
  logic signed [SB:0] b_ext;
  logic signed [SB:0] a_abs;
  logic signed [SB:0] b_abs;

  logic [SB-1:0] mag_a;
  logic [SB-1:0] mag_b;
  logic [SB-1:0] mag_n1;
  logic          neg1;
  logic          v1;

  logic [SQ_BITS-1:0] sq_a;
  logic [SQ_BITS-1:0] sq_b;
  logic [SB-1:0]      mag_n2;
  logic               neg2;
  logic               v2;

  atrp_pkg::word_t       dsq3;
  atrp_pkg::word_t       n3;
  atrp_pkg::tilt_flags_t flags3;
  logic                  v3;

  atrp_pkg::word_t       nd [NS];
  atrp_pkg::word_t       nn [NS];
  atrp_pkg::tilt_flags_t nf [NS];
  logic                  nv [NS];

  // magnitudes of the three operands
  always_comb begin
    num_abs = num[SB] ? -num : num;
    a_ext   = {a[SB-1], a};
    b_ext   = {b[SB-1], b};
    a_abs   = a_ext[SB] ? -a_ext : a_ext;
    b_abs   = b_ext[SB] ? -b_ext : b_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1 magnitudes, stage 2 squares, stage 3 sum
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a  <= a_abs[SB-1:0];
      mag_b  <= b_abs[SB-1:0];
      mag_n1 <= num_abs[SB-1:0];
      neg1   <= num[SB];

      sq_a   <= mag_a * mag_a;
      sq_b   <= mag_b * mag_b;
      mag_n2 <= mag_n1;
      neg2   <= neg1;

      dsq3            <= atrp_pkg::WORD_BITS'(sq_a) + atrp_pkg::WORD_BITS'(sq_b);
      n3              <= atrp_pkg::WORD_BITS'(mag_n2);
      flags3.neg      <= neg2;
      flags3.num_zero <= (mag_n2 == '0);
      flags3.den_zero <= (sq_a == '0) && (sq_b == '0);
    end
  end

  // greedy normalisation: steps of 16, 8, 4, 2 and 1 doublings of the numerator
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int S = 16 >> j;
    localparam atrp_pkg::word_t DLIM = atrp_pkg::word_t'(1) << (62 - 2 * S);
    localparam atrp_pkg::word_t NLIM = atrp_pkg::word_t'(1) << (61 - S);

    atrp_pkg::word_t       d_src;
    atrp_pkg::word_t       n_src;
    atrp_pkg::tilt_flags_t f_src;
    logic                  v_src;
    logic                  take;

    if (j == 0) begin : g_first
      assign d_src = dsq3;
      assign n_src = n3;
      assign f_src = flags3;
      assign v_src = v3;
    end else begin : g_next
      assign d_src = nd[j-1];
      assign n_src = nn[j-1];
      assign f_src = nf[j-1];
      assign v_src = nv[j-1];
    end

    assign take = (d_src <= DLIM) && (n_src <= NLIM);

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[j] <= 1'b0;
      end else if (en) begin
        nv[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nd[j] <= take ? (d_src << (2 * S)) : d_src;
        nn[j] <= take ? (n_src << S) : n_src;
        nf[j] <= f_src;
      end
    end
  end

  assign out_valid = nv[NS-1];
  assign dsq       = nd[NS-1];
  assign n         = nn[NS-1];
  assign flags     = nf[NS-1];

endmodule

// ===== sv/atrp_isqrt.sv =====
// pipelined floor square root, one root bit per stage
// depends on atrp_pkg
module atrp_isqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  atrp_pkg::word_t       dsq,
  input  atrp_pkg::word_t       n_in,
  input  atrp_pkg::tilt_flags_t flags_in,
  output logic                  out_valid,
  output atrp_pkg::root_t       root,
  output atrp_pkg::word_t       n_out,
  output atrp_pkg::tilt_flags_t flags_out
);

  localparam int NB = atrp_pkg::ROOT_BITS;

  atrp_pkg::word_t       s_q    [NB];
  atrp_pkg::rem_t        rem_q  [NB];
  atrp_pkg::root_t       root_q [NB];
  atrp_pkg::word_t       n_q    [NB];
  atrp_pkg::tilt_flags_t f_q    [NB];
  logic                  v_q    [NB];

  for (genvar i = 0; i < NB; i++) begin : g_bit
    atrp_pkg::word_t       s_src;
    atrp_pkg::rem_t        rem_src;
    atrp_pkg::root_t       root_src;
    atrp_pkg::word_t       n_src;
    atrp_pkg::tilt_flags_t f_src;
    logic                  v_src;
    atrp_pkg::rem_t        cand;
    atrp_pkg::rem_t        trial;
    logic                  ge;

    if (i == 0) begin : g_first
      assign s_src    = dsq;
      assign rem_src  = '0;
      assign root_src = '0;
      assign n_src    = n_in;
      assign f_src    = flags_in;
      assign v_src    = in_valid;
    end else begin : g_next
      assign s_src    = s_q[i-1];
      assign rem_src  = rem_q[i-1];
      assign root_src = root_q[i-1];
      assign n_src    = n_q[i-1];
      assign f_src    = f_q[i-1];
      assign v_src    = v_q[i-1];
    end

    // bring down the next bit pair and try the trial subtrahend
    always_comb begin
      cand  = {rem_src[atrp_pkg::REM_BITS-3:0], s_src[atrp_pkg::WORD_BITS-1 -: 2]};
      trial = {root_src, 2'b01};
      ge    = (cand >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[i]    <= s_src << 2;
        rem_q[i]  <= ge ? (cand - trial) : cand;
        root_q[i] <= {root_src[NB-2:0], ge};
        n_q[i]    <= n_src;
        f_q[i]    <= f_src;
      end
    end
  end

  assign out_valid = v_q[NB-1];
  assign root      = root_q[NB-1];
  assign n_out     = n_q[NB-1];
  assign flags_out = f_q[NB-1];

endmodule

// ===== sv/atrp_cordic.sv =====
// pipelined cordic vectoring, one micro-rotation per stage
// depends on atrp_pkg for the arctangent table and types
module atrp_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  atrp_pkg::root_t       root,
  input  atrp_pkg::word_t       n_in,
  input  atrp_pkg::tilt_flags_t flags_in,
  output logic                  out_valid,
  output atrp_pkg::angle_t      angle,
  output atrp_pkg::tilt_flags_t flags_out
);

  localparam int NS = atrp_pkg::CORDIC_STEPS;

  atrp_pkg::sword_t      x_q [NS];
  atrp_pkg::sword_t      y_q [NS];
  atrp_pkg::angle_t      z_q [NS];
  atrp_pkg::tilt_flags_t f_q [NS];
  logic                  v_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam atrp_pkg::angle_t TAB = atrp_pkg::angle_t'(atrp_pkg::atan_entry(i));

    atrp_pkg::sword_t      x_src;
    atrp_pkg::sword_t      y_src;
    atrp_pkg::angle_t      z_src;
    atrp_pkg::tilt_flags_t f_src;
    logic                  v_src;
    atrp_pkg::sword_t      xs;
    atrp_pkg::sword_t      ys;
    atrp_pkg::sword_t      x_next;
    atrp_pkg::sword_t      y_next;
    atrp_pkg::angle_t      z_next;

    if (i == 0) begin : g_first
      assign x_src = atrp_pkg::sword_t'({32'd0, root});
      assign y_src = atrp_pkg::sword_t'(n_in);
      assign z_src = '0;
      assign f_src = flags_in;
      assign v_src = in_valid;
    end else begin : g_next
      assign x_src = x_q[i-1];
      assign y_src = y_q[i-1];
      assign z_src = z_q[i-1];
      assign f_src = f_q[i-1];
      assign v_src = v_q[i-1];
    end

    // rotate toward the x axis; a zero y leaves the vector alone
    always_comb begin
      xs     = x_src >>> i;
      ys     = y_src >>> i;
      x_next = x_src;
      y_next = y_src;
      z_next = z_src;
      if (y_src > 0) begin
        x_next = x_src + ys;
        y_next = y_src - xs;
        z_next = z_src + TAB;
      end else if (y_src < 0) begin
        x_next = x_src - ys;
        y_next = y_src + xs;
        z_next = z_src - TAB;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[i] <= x_next;
        y_q[i] <= y_next;
        z_q[i] <= z_next;
        f_q[i] <= f_src;
      end
    end
  end

  assign out_valid = v_q[NS-1];
  assign angle     = z_q[NS-1];
  assign flags_out = f_q[NS-1];

endmodule

// ===== sv/atrp_scale.sv =====
// back end: clamp, scale to centidegrees with rounding, sign and special cases
// depends on atrp_pkg
module atrp_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  atrp_pkg::angle_t                     angle,
  input  atrp_pkg::tilt_flags_t                flags_in,
  output logic                                 out_valid,
  output logic signed [atrp_pkg::OUT_BITS-1:0] centideg
);

  localparam int CB = atrp_pkg::CLAMP_BITS;
  localparam int PB = atrp_pkg::PROD_BITS;
  localparam int MB = atrp_pkg::MAG_BITS;
  localparam int SHIFT = atrp_pkg::ANG_FRAC + 2;
  localparam atrp_pkg::angle_t ZMAX = atrp_pkg::angle_t'(1) <<< (atrp_pkg::ANG_FRAC + 1);
  localparam logic [PB-1:0] HALF = PB'(1) << (atrp_pkg::ANG_FRAC + 1);

  logic [CB-1:0]         zc;
  atrp_pkg::tilt_flags_t f1;
  logic                  v1;

  logic [PB-1:0]         prod_hi;
  logic [PB-1:0]         prod_lo;
  atrp_pkg::tilt_flags_t f2;
  logic                  v2;

  logic [PB-1:0]         prod_sum;
  logic [MB-1:0]         mag3;
  atrp_pkg::tilt_flags_t f3;
  logic                  v3;

  logic signed [atrp_pkg::OUT_BITS-1:0] mag_s;
  logic signed [atrp_pkg::OUT_BITS-1:0] result;

  assign prod_sum = prod_hi + prod_lo;

  // final selection: zero numerator, zero denominator, else signed magnitude
  always_comb begin
    mag_s = $signed({1'b0, mag3});
    if (f3.num_zero) begin
      result = '0;
    end else if (f3.den_zero) begin
      result = f3.neg ? -atrp_pkg::RIGHT_ANGLE : atrp_pkg::RIGHT_ANGLE;
    end else begin
      result = f3.neg ? -mag_s : mag_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp to zero..half pi
      if (angle < 0) begin
        zc <= '0;
      end else if (angle > ZMAX) begin
        zc <= ZMAX[CB-1:0];
      end else begin
        zc <= angle[CB-1:0];
      end
      f1 <= flags_in;

      // times 18000 as shifted terms, plus the rounding half
      prod_hi <= (PB'(zc) << 14) + (PB'(zc) << 10);
      prod_lo <= (PB'(zc) << 9) + (PB'(zc) << 6) + (PB'(zc) << 4) + HALF;
      f2      <= f1;

      mag3 <= prod_sum[SHIFT +: MB];
      f3   <= f2;

      centideg <= result;
    end
  end

endmodule

// ===== sv/accel_tilt_roll_pitch_unit.sv =====
// Roll and pitch from one three-axis accelerometer beat. Each accepted beat of signed
// accel_x, accel_y, accel_z yields one beat of roll = atan2(y, sqrt(x^2+z^2)) and
// pitch = atan2(-x, sqrt(y^2+z^2)) in signed hundredths of a degree, -9000..9000,
// rounded to nearest; a zero denominator gives +/-9000, or 0 when the numerator is
// zero too. A new beat is taken every clock unless a finished beat waits on out_stall;
// the stages are magnitudes, squares and sum, then normalisation, the one-bit-per-stage
// square root, the cordic micro-rotations, and scaling with the output register. The whole
// pipeline holds while a finished beat waits on out_stall. No state between beats.
// depends on atrp_pkg, atrp_norm, atrp_isqrt, atrp_cordic, atrp_scale
`include "accel_tilt_roll_pitch_unit_assert.svh"

module accel_tilt_roll_pitch_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        accel_x,
  input  logic signed [SAMPLE_BITS-1:0]        accel_y,
  input  logic signed [SAMPLE_BITS-1:0]        accel_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [atrp_pkg::OUT_BITS-1:0] roll_centideg,
  output logic signed [atrp_pkg::OUT_BITS-1:0] pitch_centideg
);

  logic en;

  logic signed [SAMPLE_BITS:0] roll_num;
  logic signed [SAMPLE_BITS:0] pitch_num;

  logic                  r_nv, p_nv;
  atrp_pkg::word_t       r_dsq, p_dsq;
  atrp_pkg::word_t       r_n1, p_n1;
  atrp_pkg::tilt_flags_t r_f1, p_f1;

  logic                  r_sv, p_sv;
  atrp_pkg::root_t       r_root, p_root;
  atrp_pkg::word_t       r_n2, p_n2;
  atrp_pkg::tilt_flags_t r_f2, p_f2;

  logic                  r_cv, p_cv;
  atrp_pkg::angle_t      r_ang, p_ang;
  atrp_pkg::tilt_flags_t r_f3, p_f3;

  logic                  pitch_valid;

  // whole pipeline advances unless the output beat is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // numerators one bit wider so that negating x is exact
  assign roll_num  = {accel_y[SAMPLE_BITS-1], accel_y};
  assign pitch_num = -{accel_x[SAMPLE_BITS-1], accel_x};

  // roll lane
  atrp_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_roll_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .num(roll_num), .a(accel_x), .b(accel_z),
    .out_valid(r_nv), .dsq(r_dsq), .n(r_n1), .flags(r_f1)
  );

  atrp_isqrt u_roll_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_nv),
    .dsq(r_dsq), .n_in(r_n1), .flags_in(r_f1),
    .out_valid(r_sv), .root(r_root), .n_out(r_n2), .flags_out(r_f2)
  );

  atrp_cordic u_roll_cordic (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_sv),
    .root(r_root), .n_in(r_n2), .flags_in(r_f2),
    .out_valid(r_cv), .angle(r_ang), .flags_out(r_f3)
  );

  atrp_scale u_roll_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_cv),
    .angle(r_ang), .flags_in(r_f3),
    .out_valid(out_valid), .centideg(roll_centideg)
  );

  // pitch lane
  atrp_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_pitch_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .num(pitch_num), .a(accel_y), .b(accel_z),
    .out_valid(p_nv), .dsq(p_dsq), .n(p_n1), .flags(p_f1)
  );

  atrp_isqrt u_pitch_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_nv),
    .dsq(p_dsq), .n_in(p_n1), .flags_in(p_f1),
    .out_valid(p_sv), .root(p_root), .n_out(p_n2), .flags_out(p_f2)
  );

  atrp_cordic u_pitch_cordic (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_sv),
    .root(p_root), .n_in(p_n2), .flags_in(p_f2),
    .out_valid(p_cv), .angle(p_ang), .flags_out(p_f3)
  );

  atrp_scale u_pitch_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_cv),
    .angle(p_ang), .flags_in(p_f3),
    .out_valid(pitch_valid), .centideg(pitch_centideg)
  );

  // checks
  `ATRP_ASSERT(lanes_in_step, pitch_valid == out_valid, "roll and pitch lanes out of step")
  `ATRP_ASSERT(roll_in_range, out_valid |-> (roll_centideg <= 15'sd9000 && roll_centideg >= -15'sd9000), "roll out of range")
  `ATRP_ASSERT(pitch_in_range, out_valid |-> (pitch_centideg <= 15'sd9000 && pitch_centideg >= -15'sd9000), "pitch out of range")
  `ATRP_ASSERT(reset_clears_out, $past(rst) |-> !out_valid, "output valid after reset")

endmodule
